[design/lmkc_pkg.sv]
`timescale 1ns / 1ps
package lmkc_pkg;

   localparam int SetupRounds = 12;
   localparam int CntWidth    = 4;
   localparam int CsrIdxWidth = 3;

   typedef enum logic {
      OP_RESTART = 1'b0,
      OP_ENCRYPT = 1'b1
   } lmkc_op_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_IV0  = 3'd4,
      CSR_IV1  = 3'd5
   } lmkc_csr_idx_type;

   typedef struct packed {
      logic [127:0] hi;
      logic [127:0] lo;
      logic [127:0] nf;
      logic [127:0] s0;
      logic [127:0] s1;
      logic [127:0] s2;
   } lmkc_state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [15:0] LANE_C [8] = '{
      16'h35c9, 16'h952b, 16'hd4b1, 16'h4ab5, 16'ha291, 16'h7eed, 16'ha31b, 16'h7ca1
   };

   localparam logic [3:0] SIGMA [16] = '{
      4'd2, 4'd3, 4'd4, 4'd5, 4'd14, 4'd15, 4'd8, 4'd9,
      4'd12, 4'd13, 4'd6, 4'd7, 4'd0, 4'd1, 4'd10, 4'd11
   };

   function automatic logic [7:0] xt(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // One AES round: SubBytes, ShiftRows, MixColumns, then the round key.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4*c] = SBOX[s[8*(r + 4*((c + r) & 3)) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0  = t[4*c];
         a1  = t[4*c + 1];
         a2  = t[4*c + 2];
         a3  = t[4*c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         o[8*(4*c)     +: 8] = a0 ^ all ^ xt(a0 ^ a1) ^ k[8*(4*c)     +: 8];
         o[8*(4*c + 1) +: 8] = a1 ^ all ^ xt(a1 ^ a2) ^ k[8*(4*c + 1) +: 8];
         o[8*(4*c + 2) +: 8] = a2 ^ all ^ xt(a2 ^ a3) ^ k[8*(4*c + 2) +: 8];
         o[8*(4*c + 3) +: 8] = a3 ^ all ^ xt(a3 ^ a0) ^ k[8*(4*c + 3) +: 8];
      end
      return o;
   endfunction

endpackage

[design/lmkc_if.sv]
`timescale 1ns / 1ps
interface lmkc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [63:0] block_low;
   logic [63:0] block_high;
   modport source (output valid, opcode, block_low, block_high, input ready);
   modport sink (input valid, opcode, block_low, block_high, output ready);
endinterface

interface lmkc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_low;
   logic [63:0] cipher_high;
   modport source (output valid, cipher_low, cipher_high, input ready);
   modport sink (input valid, cipher_low, cipher_high, output ready);
endinterface

interface lmkc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/lmkc_csr.sv]
`timescale 1ns / 1ps
module lmkc_csr
   import lmkc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   lmkc_csr_if.sink     csr_if,
   output logic [255:0] key,
   output logic [127:0] iv
);

   logic [63:0] key_ff [4];
   logic [63:0] iv_ff  [2];
   logic        wr;

   assign csr_if.ready = 1'b1;
   assign wr           = csr_if.valid;
   assign key          = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
   assign iv           = {iv_ff[1], iv_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{default: '0};
         iv_ff  <= '{default: '0};
      end else if (wr) begin
         unique case (lmkc_csr_idx_type'(csr_if.index))
            CSR_KEY0: key_ff[0] <= csr_if.data;
            CSR_KEY1: key_ff[1] <= csr_if.data;
            CSR_KEY2: key_ff[2] <= csr_if.data;
            CSR_KEY3: key_ff[3] <= csr_if.data;
            CSR_IV0:  iv_ff[0]  <= csr_if.data;
            CSR_IV1:  iv_ff[1]  <= csr_if.data;
            default: ;
         endcase
      end
   end

endmodule

[design/lmkc_update.sv]
`timescale 1ns / 1ps
module lmkc_update
   import lmkc_pkg::*;
(
   input  lmkc_state_type cur,
   output logic [127:0]   keystream,
   output lmkc_state_type nxt
);

   logic [127:0] inter;
   logic [127:0] nhi;
   logic [15:0]  h, d;

   always_comb begin
      inter     = aes_round(cur.s2, '0);
      keystream = inter ^ cur.nf;
      nhi       = '0;
      h         = '0;
      d         = '0;
      for (int i = 0; i < 8; i++) begin
         h = cur.hi[16*i +: 16];
         d = {h[14:0], 1'b0} ^ (h[15] ? LANE_C[i] : 16'h0000);
         nhi[16*i +: 16] = d ^ {cur.lo[8*SIGMA[2*i + 1] +: 8], cur.lo[8*SIGMA[2*i] +: 8]};
      end
      nxt.hi = nhi;
      nxt.lo = cur.hi;
      nxt.nf = aes_round(cur.nf, cur.lo);
      nxt.s2 = aes_round(cur.s1, cur.s2);
      nxt.s1 = aes_round(cur.s0, cur.s1);
      nxt.s0 = cur.s0 ^ nhi ^ inter;
   end

endmodule

[design/lol_mini_keystream_cipher.sv]
`timescale 1ns / 1ps
// Keystream cipher engine with three valid/ready channels.
// csr_if: register writes (index 0..3 key words, 4..5 IV words), always ready;
// write them only while the engine is idle.
// req_if: opcode 0 restarts from the key and IV, opcode 1 encrypts one
// 128-bit block held in block_low/block_high.
// rsp_if: one ciphertext word per encrypt word, in order.
// An encrypt word's result is in the output register the cycle after acceptance;
// a new encrypt word may be taken every cycle unless setup rounds or a receiver stall hold req_if.ready low.
// A restart produces no word and keeps req_if.ready low while the setup rounds
// run through the single round datapath, one per cycle.
// If the receiver stalls, the result register holds its word and req_if.ready
// drops until it is taken or taken in the same cycle.
// Synchronous reset clears the key, IV, cipher state and round counter to zero and
// empties the output register; the output data itself is not cleared.
module lol_mini_keystream_cipher
   import lmkc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lmkc_csr_if.sink  csr_if,
   lmkc_req_if.sink  req_if,
   lmkc_rsp_if.source rsp_if
);

   logic [255:0]         key;
   logic [127:0]         iv;
   lmkc_state_type       st_ff, st_in, nxt;
   logic [127:0]         ks;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 vld_ff, vld_in;
   logic [127:0]         out_ff, out_in;
   logic                 busy, accept;

   lmkc_csr u_csr (.clock(clock), .reset(reset), .csr_if(csr_if), .key(key), .iv(iv));

   lmkc_update u_update (.cur(st_ff), .keystream(ks), .nxt(nxt));

   assign busy         = (cnt_ff != '0);
   assign req_if.ready = !busy && (!vld_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff && !rsp_if.ready;
      out_in = out_ff;
      if (busy) begin
         st_in    = nxt;
         st_in.nf = nxt.nf ^ ks;
         st_in.hi = nxt.hi ^ ks;
         cnt_in   = cnt_ff - 1'b1;
         // The last setup round also folds the key halves in.
         if (cnt_ff == CntWidth'(1)) begin
            st_in.s0 = nxt.s0 ^ key[255:128];
            st_in.hi = nxt.hi ^ ks ^ key[127:0];
         end
      end else if (accept) begin
         if (lmkc_op_type'(req_if.opcode) == OP_RESTART) begin
            st_in.s0 = iv;
            st_in.s1 = key[255:128];
            st_in.s2 = key[127:0];
            st_in.hi = '0;
            st_in.lo = '0;
            st_in.nf = '0;
            cnt_in   = CntWidth'(SetupRounds);
         end else begin
            st_in  = nxt;
            vld_in = 1'b1;
            out_in = {req_if.block_high, req_if.block_low} ^ ks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid       = vld_ff;
   assign rsp_if.cipher_low  = out_ff[63:0];
   assign rsp_if.cipher_high = out_ff[127:64];

`ifndef SYNTH
   a_restart_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.opcode == OP_RESTART |=> cnt_ff == CntWidth'(SetupRounds))
      else $error("restart did not start setup rounds");
   a_encrypt_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.opcode == OP_ENCRYPT |=> vld_ff)
      else $error("encrypt word produced no result");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      busy |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("setup counter did not step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_if.ready)
      else $error("input ready during setup");
`endif

endmodule

[tb/lmkc_tb_if.sv]
`timescale 1ns / 1ps
// The block's interfaces are reused as they are; this file holds the
// testbench's own descriptor of one queued word.
package lmkc_tb_pkg;
   import lmkc_pkg::*;

   typedef struct {
      lmkc_op_type op;
      logic [63:0] lo;
      logic [63:0] hi;
   } cipher_word_type;
endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import lmkc_pkg::*;
   import lmkc_tb_pkg::*;

   localparam logic [15:0] LaneConst [8] = '{
      16'h35c9, 16'h952b, 16'hd4b1, 16'h4ab5, 16'ha291, 16'h7eed, 16'ha31b, 16'h7ca1
   };
   localparam int LaneSel [16] = '{2, 3, 4, 5, 14, 15, 8, 9, 12, 13, 6, 7, 0, 1, 10, 11};
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lmkc_csr_if csr_if();
   lmkc_req_if req_if();
   lmkc_rsp_if rsp_if();

   lol_mini_keystream_cipher i_dut (
      .clock(clock), .reset(reset), .csr_if(csr_if), .req_if(req_if), .rsp_if(rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0] sub_table [256];
   logic [63:0] key_reg [4];
   logic [63:0] iv_reg [2];
   logic [127:0] lfsr_hi, lfsr_lo, nlfsr, fsm0, fsm1, fsm2;

   cipher_word_type pending_words [$];
   logic [127:0] expected_cipher [$];
   int failures = 0;
   int cycle_count = 0;
   bit long_hold = 1'b0;
   bit sender_pause = 1'b0;
   bit in_taken = 1'b0;

   function automatic logic [7:0] times_two(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] round_mix(logic [127:0] s, logic [127:0] k);
      logic [7:0] t [16];
      logic [7:0] b0, b1, b2, b3, sum;
      logic [127:0] o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[r + 4*c] = sub_table[s[8*(r + 4*((c + r) % 4)) +: 8]];
      for (int c = 0; c < 4; c++) begin
         b0 = t[4*c]; b1 = t[4*c+1]; b2 = t[4*c+2]; b3 = t[4*c+3];
         sum = b0 ^ b1 ^ b2 ^ b3;
         o[32*c      +: 8] = b0 ^ sum ^ times_two(b0 ^ b1) ^ k[32*c      +: 8];
         o[32*c + 8  +: 8] = b1 ^ sum ^ times_two(b1 ^ b2) ^ k[32*c + 8  +: 8];
         o[32*c + 16 +: 8] = b2 ^ sum ^ times_two(b2 ^ b3) ^ k[32*c + 16 +: 8];
         o[32*c + 24 +: 8] = b3 ^ sum ^ times_two(b3 ^ b0) ^ k[32*c + 24 +: 8];
      end
      return o;
   endfunction

   // Returns the keystream block and steps the cipher state once.
   function automatic logic [127:0] next_keystream();
      logic [127:0] mixed, ks, new_hi, n1, n2;
      logic [15:0] lane, dbl;
      mixed = round_mix(fsm2, '0);
      ks = mixed ^ nlfsr;
      for (int i = 0; i < 8; i++) begin
         lane = lfsr_hi[16*i +: 16];
         dbl = {lane[14:0], 1'b0} ^ (lane[15] ? LaneConst[i] : 16'h0);
         new_hi[16*i +: 8] = dbl[7:0] ^ lfsr_lo[8*LaneSel[2*i] +: 8];
         new_hi[16*i + 8 +: 8] = dbl[15:8] ^ lfsr_lo[8*LaneSel[2*i+1] +: 8];
      end
      n2 = round_mix(fsm1, fsm2);
      n1 = round_mix(fsm0, fsm1);
      fsm0 = new_hi ^ mixed ^ fsm0;
      fsm1 = n1;
      fsm2 = n2;
      nlfsr = round_mix(nlfsr, lfsr_lo);
      lfsr_lo = lfsr_hi;
      lfsr_hi = new_hi;
      return ks;
   endfunction

   task automatic predict_word(cipher_word_type w);
      logic [127:0] ks;
      if (w.op == OP_RESTART) begin
         fsm0 = {iv_reg[1], iv_reg[0]};
         fsm1 = {key_reg[3], key_reg[2]};
         fsm2 = {key_reg[1], key_reg[0]};
         lfsr_hi = '0; lfsr_lo = '0; nlfsr = '0;
         for (int r = 0; r < SetupRounds; r++) begin
            ks = next_keystream();
            nlfsr ^= ks;
            lfsr_hi ^= ks;
         end
         fsm0 ^= {key_reg[3], key_reg[2]};
         lfsr_hi ^= {key_reg[1], key_reg[0]};
      end else begin
         ks = next_keystream();
         expected_cipher.push_back({w.hi, w.lo} ^ ks);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_value(int k);
      case (k % 4)
         0: return 64'h0;
         1: return '1;
         2: return 64'h8000_0000_0000_0001;
         default: return rand64();
      endcase
   endfunction

   task automatic queue_word(lmkc_op_type op, logic [63:0] lo, logic [63:0] hi);
      cipher_word_type w;
      w.op = op; w.lo = lo; w.hi = hi;
      pending_words.push_back(w);
   endtask

   // Register writes happen only with the engine idle, so the model sees
   // them immediately.
   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx < 3'd4) key_reg[idx[1:0]] = value;
      else if (idx < 3'd6) iv_reg[idx[0]] = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_cipher.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.opcode <= OP_ENCRYPT;
         req_if.block_low <= '0;
         req_if.block_high <= '0;
      end else if (!req_if.valid || in_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() != 0 && !sender_pause) begin
            req_if.valid <= 1'b1;
            req_if.opcode <= pending_words[0].op;
            req_if.block_low <= pending_words[0].lo;
            req_if.block_high <= pending_words[0].hi;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else burst_left <= burst_left - 1;
         end else req_if.valid <= 1'b0;
      end
   end

   // Prediction runs at acceptance, checking of returned words likewise.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      in_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         predict_word(pending_words[0]);
         void'(pending_words.pop_front());
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_cipher.size() == 0) begin
            $display("%0t: unexpected word actual %h_%h", $realtime,
                     rsp_if.cipher_high, rsp_if.cipher_low);
            failures++;
         end else begin
            if (rsp_if.cipher_low !== expected_cipher[0][63:0]) begin
               $display("%0t: cipher_low expected %h actual %h", $realtime,
                        expected_cipher[0][63:0], rsp_if.cipher_low);
               failures++;
            end
            if (rsp_if.cipher_high !== expected_cipher[0][127:64]) begin
               $display("%0t: cipher_high expected %h actual %h", $realtime,
                        expected_cipher[0][127:64], rsp_if.cipher_high);
               failures++;
            end
            void'(expected_cipher.pop_front());
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Receiver: stalls on a slowly changing random duty, with one long
   // hold-off.
   int stall_pct = 0;
   int hold_count = 0;
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else if (long_hold && hold_count < 200) begin
         hold_count <= hold_count + 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_pct <= $urandom_range(0, 3) * 25;
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) queue_word(OP_RESTART, rand64(), rand64());
         else queue_word(OP_ENCRYPT, rand64(), rand64());
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) sub_table[i] = SBOX[i];
      lfsr_hi = '0; lfsr_lo = '0; nlfsr = '0; fsm0 = '0; fsm1 = '0; fsm2 = '0;
      key_reg = '{default: '0};
      iv_reg = '{default: '0};
      csr_if.valid = 1'b0;
      csr_if.index = CSR_KEY0;
      csr_if.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Encrypt straight after reset, with all state zero, then restart with the zero key and encrypt again.
      for (int k = 0; k < 4; k++) queue_word(OP_ENCRYPT, edge_value(k), edge_value(k + 1));
      queue_word(OP_RESTART, '1, '1);
      queue_word(OP_ENCRYPT, '0, '0);
      wait_idle();

      for (int k = 0; k < 3; k++) begin
         write_reg(CSR_KEY0, edge_value(k + 1));
         write_reg(CSR_KEY1, edge_value(k + 2));
         write_reg(CSR_KEY2, edge_value(k + 3));
         write_reg(CSR_KEY3, edge_value(k));
         write_reg(CSR_IV0, edge_value(k + 1));
         write_reg(CSR_IV1, edge_value(k + 2));
         // Out-of-range indexes must be ignored.
         write_reg(3'd6, rand64());
         write_reg(3'd7, rand64());
         queue_word(OP_RESTART, '0, '0);
         queue_word(OP_ENCRYPT, '1, '0);
         queue_word(OP_ENCRYPT, '0, '1);
         queue_word(OP_RESTART, rand64(), rand64());
         queue_word(OP_RESTART, '0, '0);
         queue_word(OP_ENCRYPT, rand64(), rand64());
         wait_idle();
      end

      for (int p = 0; p < 6; p++) begin
         for (int r = 0; r < 6; r++) write_reg(r[2:0], rand64());
         queue_word(OP_RESTART, '0, '0);
         random_phase(300);
         if (p == 2) begin
            long_hold = 1'b1;
         end
         if (p == 4) begin
            // Pause the sender with words still queued, let the outstanding results drain, then resume with a burst.
            while (pending_words.size() > 150) @(posedge clock);
            sender_pause = 1'b1;
            while (expected_cipher.size() != 0) @(posedge clock);
            sender_pause = 1'b0;
         end
         wait_idle();
      end
      if (failures == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
